// ----- rtl/retry_backoff_staleness_monitor_defines.svh -----
// Assertion helpers used by the monitor RTL.
`ifndef RETRY_BACKOFF_STALENESS_MONITOR_DEFINES_SVH
`define RETRY_BACKOFF_STALENESS_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rbsm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RBSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rbsm assertion failed");

`endif

// ----- rtl/rbsm_pkg.sv -----
package rbsm_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int FIELD_TIME_W  = 32;
	localparam int CFG_DATA_W    = 24;
	localparam int CFG_IDX_W     = 2;
	localparam int FAIL_W        = 16;

	localparam logic [CFG_IDX_W-1:0] REG_REFRESH_INTERVAL     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STALE_THRESHOLD      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALERT_AFTER_FAILURES = 2'd2;

	localparam logic [23:0] REFRESH_RST = 24'd600;
	localparam logic [23:0] STALE_RST   = 24'd1800;
	localparam logic [15:0] ALERT_RST   = 16'd5;

	localparam logic [FAIL_W-1:0] FAIL_MAX = 16'hFFFF;

	// 30 << 20 already exceeds any 24-bit cap, so the shift never needs more.
	localparam int BACKOFF_W         = 25;
	localparam int BACKOFF_SHIFT_MAX = 20;
	localparam logic [BACKOFF_W-1:0] BACKOFF_BASE = 25'd30;

	typedef struct packed {
		logic [23:0] refresh_interval;
		logic [23:0] stale_threshold;
		logic [15:0] alert_after_failures;
	} cfg_t;

	// min(30 * 2^(fails-1), cap); fails is at least one here.
	function automatic logic [23:0] backoff_delay(input logic [FAIL_W-1:0] fails,
			input logic [23:0] cap);
		logic [FAIL_W-1:0]    k_full;
		logic [4:0]           k;
		logic [BACKOFF_W-1:0] delay;
		k_full = (fails == '0) ? '0 : fails - 16'd1;
		k      = (k_full > FAIL_W'(BACKOFF_SHIFT_MAX)) ? 5'(BACKOFF_SHIFT_MAX) : k_full[4:0];
		delay  = BACKOFF_BASE << k;
		return (delay > BACKOFF_W'(cap)) ? cap : delay[23:0];
	endfunction

endpackage

// ----- rtl/rbsm_ifs.sv -----
interface rbsm_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] now;
	logic        fetch_ok;
	logic [31:0] report_time;

	modport source (output valid, action, now, fetch_ok, report_time, input ready);
	modport sink   (input valid, action, now, fetch_ok, report_time, output ready);
endinterface

interface rbsm_rsp_if;
	logic        valid;
	logic        ready;
	logic        fetch_due;
	logic        is_stale;
	logic        alert;
	logic [31:0] next_fetch_time;
	logic [15:0] failure_count;

	modport source (output valid, fetch_due, is_stale, alert, next_fetch_time, failure_count,
		input ready);
	modport sink   (input valid, fetch_due, is_stale, alert, next_fetch_time, failure_count,
		output ready);
endinterface

// ----- rtl/rbsm_cfg_regs.sv -----
module rbsm_cfg_regs
	import rbsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t        cfg_q;
	logic [23:0] wdata_24;
	logic [15:0] wdata_16;

	// a zero write behaves as one, so fold it here once
	assign wdata_24 = (cfg_wdata == '0) ? 24'd1 : cfg_wdata;
	assign wdata_16 = (cfg_wdata[15:0] == '0) ? 16'd1 : cfg_wdata[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.refresh_interval     <= REFRESH_RST;
			cfg_q.stale_threshold      <= STALE_RST;
			cfg_q.alert_after_failures <= ALERT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_REFRESH_INTERVAL:     cfg_q.refresh_interval     <= wdata_24;
				REG_STALE_THRESHOLD:      cfg_q.stale_threshold      <= wdata_24;
				REG_ALERT_AFTER_FAILURES: cfg_q.alert_after_failures <= wdata_16;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/retry_backoff_staleness_monitor.sv -----
// Retry backoff and staleness monitor. Each request word carries a time and either
// asks for status (action 0) or reports a fetch outcome (action 1). A success stores
// the data timestamp, clears the failure count and schedules the next fetch one
// refresh interval ahead; a failure bumps the saturating count and schedules a retry
// after min(30 * 2^(n-1), refresh interval). Every request returns one response word
// with the state after the update: fetch_due, is_stale, alert, next_fetch_time
// (0 = unset) and failure_count. Throughput is one word per cycle unless rsp.ready
// stalls the output: the request register feeds the update logic, whose state registers
// and response register load on the same edge, so each request sees the prior update.
// Configuration writes go straight to the register file; write only while idle.
// A zero register value acts as one. Times wrap modulo 2^TIME_BITS.
`include "retry_backoff_staleness_monitor_defines.svh"

module retry_backoff_staleness_monitor
	import rbsm_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	rbsm_req_if.sink              req,
	rbsm_rsp_if.source            rsp
);

	// wide enough for time + 24-bit delay without overflow
	localparam int SUM_W = ((TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W) + 1;

	cfg_t cfg;

	rbsm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// stage 1: request register
	logic                 valid_s1;
	logic                 action_s1;
	logic                 ok_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [TIME_BITS-1:0] rtime_s1;

	// stage 2: response register
	logic                    rsp_valid_s2;
	logic                    due_s2;
	logic                    stale_s2;
	logic                    alert_s2;
	logic [TIME_BITS-1:0]    nft_s2;
	logic [FAIL_W-1:0]       fail_s2;

	// monitor state
	logic [TIME_BITS-1:0] next_q;
	logic [FAIL_W-1:0]    fail_q;
	logic                 dvalid_q;
	logic [TIME_BITS-1:0] ts_q;

	logic advance;
	logic fire;

	// response slot frees when empty or being taken
	assign advance   = !rsp_valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign fire      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			action_s1 <= req.action;
			ok_s1     <= req.fetch_ok;
			now_s1    <= TIME_BITS'(req.now);
			rtime_s1  <= TIME_BITS'(req.report_time);
		end
	end

	// update logic
	logic                 succ;
	logic [FAIL_W-1:0]    fail_inc;
	logic [FAIL_W-1:0]    fail_nx;
	logic [23:0]          delay;
	logic [SUM_W-1:0]     sum;
	logic [TIME_BITS-1:0] next_nx;
	logic                 dvalid_nx;
	logic [TIME_BITS-1:0] ts_nx;
	logic [TIME_BITS-1:0] age;
	logic                 due;
	logic                 stale;
	logic                 alert;

	assign succ     = action_s1 && ok_s1;
	assign fail_inc = (fail_q == FAIL_MAX) ? fail_q : fail_q + 16'd1;

	always_comb begin
		fail_nx   = fail_q;
		dvalid_nx = dvalid_q;
		ts_nx     = ts_q;
		if (action_s1) begin
			if (ok_s1) begin
				fail_nx   = '0;
				dvalid_nx = 1'b1;
				ts_nx     = rtime_s1;
			end else begin
				fail_nx   = fail_inc;
			end
		end
	end

	assign delay   = succ ? cfg.refresh_interval : backoff_delay(fail_inc, cfg.refresh_interval);
	assign sum     = SUM_W'(now_s1) + SUM_W'(delay);
	assign next_nx = action_s1 ? sum[TIME_BITS-1:0] : next_q;

	// a schedule of zero reads as unset, so a fetch is due
	assign due   = (next_nx == '0) || (now_s1 >= next_nx);
	// data stamped in the future has age zero
	assign age   = (now_s1 >= ts_nx) ? now_s1 - ts_nx : '0;
	assign stale = !dvalid_nx || (SUM_W'(age) > SUM_W'(cfg.stale_threshold));
	assign alert = (fail_nx >= cfg.alert_after_failures) && stale;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q   <= '0;
			fail_q   <= '0;
			dvalid_q <= 1'b0;
			ts_q     <= '0;
		end else if (fire) begin
			next_q   <= next_nx;
			fail_q   <= fail_nx;
			dvalid_q <= dvalid_nx;
			ts_q     <= ts_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			rsp_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			due_s2   <= due;
			stale_s2 <= stale;
			alert_s2 <= alert;
			nft_s2   <= next_nx;
			fail_s2  <= fail_nx;
		end
	end

	assign rsp.valid           = rsp_valid_s2;
	assign rsp.fetch_due       = due_s2;
	assign rsp.is_stale        = stale_s2;
	assign rsp.alert           = alert_s2;
	assign rsp.next_fetch_time = FIELD_TIME_W'(nft_s2);
	assign rsp.failure_count   = fail_s2;

	`RBSM_ASSERT_NEXT(a_fail_saturates, clk, arst_n,
		fire && action_s1 && !ok_s1 && fail_q == FAIL_MAX, fail_q == FAIL_MAX)
	`RBSM_ASSERT_NEXT(a_success_clears, clk, arst_n,
		fire && succ, fail_q == '0 && dvalid_q)
	`RBSM_ASSERT_NEXT(a_state_holds_idle, clk, arst_n,
		!fire, $stable(fail_q) && $stable(next_q) && $stable(ts_q))
	`RBSM_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !rsp_valid_s2, req.ready)
	`RBSM_ASSERT_NOW(a_alert_needs_stale, clk, arst_n, rsp_valid_s2 && alert_s2, stale_s2)

endmodule
